// ===== src/ufd_pkg.sv =====
// Package for the UART frame deframer: frame sizes, store geometry,
// register indexes, state type and the store access bundle. No dependencies.
package ufd_pkg;

  // Frame sizes in bytes
  localparam int DATA_FRAME_BYTES = 12;
  localparam int ECHO_FRAME_BYTES = 10;
  localparam int STORE_DEPTH      = (DATA_FRAME_BYTES > ECHO_FRAME_BYTES) ?
                                    DATA_FRAME_BYTES : ECHO_FRAME_BYTES;

  // Widths
  localparam int BYTE_W   = 8;
  localparam int POS_W    = 4;
  localparam int ADDR_W   = $clog2(STORE_DEPTH);
  localparam int FILL_W   = $clog2(STORE_DEPTH + 1);
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DATA_FIRST  = 2'd0,
    CFG_DATA_SECOND = 2'd1,
    CFG_ECHO_FIRST  = 2'd2,
    CFG_ECHO_SECOND = 2'd3
  } ufd_cfg_idx_e;

  // Top-level control state
  typedef enum logic {
    ST_COLLECT,
    ST_EMIT
  } ufd_state_e;

  // One write port and one read port into the frame store
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [BYTE_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ufd_store_req_t;

endpackage

// ===== src/ufd_frame_store.sv =====
// Frame byte store: synchronous memory, one write and one registered read
// per cycle. Depends on ufd_pkg.
module ufd_frame_store
  import ufd_pkg::*;
(
  input  logic              clk_i,
  input  ufd_store_req_t    req_i,
  output logic [BYTE_W-1:0] rdata_o
);

  logic [BYTE_W-1:0] mem_q [STORE_DEPTH];
  logic [BYTE_W-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  // Read port, data registered; holds until the next read
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/uart_frame_deframer_unit.sv =====
// UART frame deframer top level: header hunt, frame fill and frame emission.
// Depends on ufd_pkg and ufd_frame_store.
//
// Usage:
//   rx channel (rx_valid_i/rx_ready_o/rx_byte_i) takes one received byte per
//   item. The out channel (out_valid_o/out_ready_i) gives frame_byte_o,
//   byte_position_o and last_of_frame_o for each byte of a completed data
//   frame, header included, last_of_frame_o marking the final byte.
//   Header registers are written through cfg_we_i/cfg_index_i/cfg_data_i.
// Timing:
//   A byte that does not complete a data frame is accepted and rx_ready_o
//   stays high. A byte that completes a data frame starts emission: the
//   first result appears once the state register has entered emission and
//   the first store read has been registered, then one result per cycle
//   while out_ready_i is high, 12 results per frame. The frame store has a
//   single read port, so emission reads one byte per cycle. rx_ready_o is
//   low after the completing byte is accepted until the last result is taken.
// Reset: header registers clear to zero, the block hunts for a header and
//   the store contents are left as they are.
// Stall: while out_ready_i is low the current result holds and no further
//   store read is issued.
module uart_frame_deframer_unit
  import ufd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [BYTE_W-1:0]    cfg_data_i,
  // Received bytes
  input  logic                 rx_valid_i,
  output logic                 rx_ready_o,
  input  logic [BYTE_W-1:0]    rx_byte_i,
  // Frame bytes out
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [BYTE_W-1:0]    frame_byte_o,
  output logic [POS_W-1:0]     byte_position_o,
  output logic                 last_of_frame_o
);

  localparam logic [FILL_W-1:0] DataLen  = FILL_W'(DATA_FRAME_BYTES);
  localparam logic [FILL_W-1:0] EchoLen  = FILL_W'(ECHO_FRAME_BYTES);
  localparam logic [FILL_W-1:0] StoreLen = FILL_W'(STORE_DEPTH);
  localparam logic [FILL_W-1:0] LastPos  = FILL_W'(DATA_FRAME_BYTES - 1);

  logic [BYTE_W-1:0] data_first_q, data_second_q, echo_first_q, echo_second_q;
  logic [BYTE_W-1:0] first_q, first_d;
  logic [FILL_W-1:0] fill_q, fill_d, fill_inc;
  logic [FILL_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [FILL_W-1:0] pos_q, pos_d;
  logic              out_valid_q, out_valid_d;
  logic              last_q, last_d;
  ufd_state_e        state_q, state_d;
  ufd_store_req_t    store_req;
  logic [BYTE_W-1:0] store_rdata;
  logic              rx_fire, out_fire, issue;
  logic              hdr_first_hit, hdr_second_ok;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_first_q  <= '0;
      data_second_q <= '0;
      echo_first_q  <= '0;
      echo_second_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_DATA_FIRST:  data_first_q  <= cfg_data_i;
        CFG_DATA_SECOND: data_second_q <= cfg_data_i;
        CFG_ECHO_FIRST:  echo_first_q  <= cfg_data_i;
        CFG_ECHO_SECOND: echo_second_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign rx_ready_o = (state_q == ST_COLLECT);
  assign rx_fire    = rx_valid_i && rx_ready_o;
  assign out_fire   = out_valid_q && out_ready_i;
  assign fill_inc   = fill_q + FILL_W'(1);

  assign hdr_first_hit = (rx_byte_i == data_first_q) || (rx_byte_i == echo_first_q);
  assign hdr_second_ok = ((first_q == data_first_q) && (rx_byte_i == data_second_q)) ||
                         ((first_q == echo_first_q) && (rx_byte_i == echo_second_q));

  // Issue the next store read when the output slot frees up
  assign issue = (state_q == ST_EMIT) && (rd_ptr_q < DataLen) &&
                 (!out_valid_q || out_ready_i);

  // Next state, fill tracking, store accesses and emission
  always_comb begin
    state_d         = state_q;
    fill_d          = fill_q;
    first_d         = first_q;
    rd_ptr_d        = rd_ptr_q;
    pos_d           = pos_q;
    last_d          = last_q;
    out_valid_d     = out_valid_q;
    store_req.we    = 1'b0;
    store_req.waddr = fill_q[ADDR_W-1:0];
    store_req.wdata = rx_byte_i;
    store_req.re    = issue;
    store_req.raddr = rd_ptr_q[ADDR_W-1:0];

    unique case (state_q)
      ST_COLLECT: begin
        if (rx_fire) begin
          if (fill_q == '0) begin
            // hunting for the first header byte
            if (hdr_first_hit) begin
              store_req.we = 1'b1;
              first_d      = rx_byte_i;
              fill_d       = FILL_W'(1);
            end
          end else if (fill_q == FILL_W'(1)) begin
            // second header byte must complete the header
            if (hdr_second_ok) begin
              store_req.we = 1'b1;
              fill_d       = FILL_W'(2);
            end else begin
              fill_d = '0;
            end
          end else begin
            store_req.we = (fill_q < StoreLen);
            if ((first_q == data_first_q) && (fill_inc >= DataLen)) begin
              fill_d   = '0;
              rd_ptr_d = '0;
              state_d  = ST_EMIT;
            end else if ((first_q == echo_first_q) && (fill_inc >= EchoLen)) begin
              fill_d = '0;
            end else if (fill_inc >= StoreLen) begin
              fill_d = '0;
            end else begin
              fill_d = fill_inc;
            end
          end
        end
      end
      ST_EMIT: begin
        if (issue) begin
          out_valid_d = 1'b1;
          pos_d       = rd_ptr_q;
          last_d      = (rd_ptr_q == LastPos);
          rd_ptr_d    = rd_ptr_q + FILL_W'(1);
        end else if (out_fire) begin
          out_valid_d = 1'b0;
          if (last_q) begin
            state_d = ST_COLLECT;
          end
        end
      end
      default: state_d = ST_COLLECT;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_COLLECT;
      fill_q      <= '0;
      rd_ptr_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      rd_ptr_q    <= rd_ptr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    first_q <= first_d;
    pos_q   <= pos_d;
    last_q  <= last_d;
  end

  ufd_frame_store u_store (
    .clk_i   (clk_i),
    .req_i   (store_req),
    .rdata_o (store_rdata)
  );

  assign out_valid_o     = out_valid_q;
  assign frame_byte_o    = store_rdata;
  assign byte_position_o = POS_W'(pos_q);
  assign last_of_frame_o = last_q;

  // Input and output sides never both active
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rx_ready_o && out_valid_o))
    else $error("rx accepted during frame emission");

  // Final byte carries the last frame position
  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_of_frame_o) |-> (byte_position_o == POS_W'(LastPos)))
    else $error("last marker on wrong position");

  // A taken non-final byte is followed at once by the next position
  a_pos_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_of_frame_o) |=>
      (out_valid_o && (byte_position_o == $past(byte_position_o) + POS_W'(1))))
    else $error("frame position skipped");

  // Fill level stays inside the store
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q < StoreLen)
    else $error("fill level out of range");

endmodule
